// ----- hw/rtl/esi_pkg.sv -----
// Package: types, character constants and decode helpers for the escape sequence interpreter.
`timescale 1ns / 1ps

package esi_pkg;

  // Number of quote slots honored by the quote-set compare (at most four registers exist)
  localparam int unsigned QUOTE_SLOTS = 4;
  localparam int unsigned QUOTE_REGS  = 4;
  localparam int unsigned QUOTE_LIMIT = (QUOTE_SLOTS < QUOTE_REGS) ? QUOTE_SLOTS : QUOTE_REGS;

  localparam int unsigned CHAR_W   = 16;
  localparam int unsigned ACCUM_W  = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned MAX_RESULTS = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BACKREF_MODE = 3'd0,
    CFG_QUOTE_COUNT  = 3'd1,
    CFG_QUOTE_CHAR_A = 3'd2,
    CFG_QUOTE_CHAR_B = 3'd3,
    CFG_QUOTE_CHAR_C = 3'd4,
    CFG_QUOTE_CHAR_D = 3'd5
  } cfg_index_t;

  // Parser state
  typedef enum logic [2:0] {
    MODE_PLAIN     = 3'd0,
    MODE_ESC       = 3'd1,
    MODE_CTRL      = 3'd2,
    MODE_HEX_START = 3'd3,
    MODE_HEX_DIGIT = 3'd4,
    MODE_OCTAL     = 3'd5
  } parse_mode_t;

  // Characters the parser reacts to
  localparam logic [CHAR_W-1:0] CH_NUL    = 16'h0000;
  localparam logic [CHAR_W-1:0] CH_BSL    = 16'h005C;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 16'h007B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 16'h007D;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 16'h0027;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 16'h0022;
  localparam logic [CHAR_W-1:0] CH_LOW_A  = 16'h0061;
  localparam logic [CHAR_W-1:0] CH_LOW_C  = 16'h0063;
  localparam logic [CHAR_W-1:0] CH_LOW_E  = 16'h0065;
  localparam logic [CHAR_W-1:0] CH_LOW_F  = 16'h0066;
  localparam logic [CHAR_W-1:0] CH_LOW_N  = 16'h006E;
  localparam logic [CHAR_W-1:0] CH_LOW_R  = 16'h0072;
  localparam logic [CHAR_W-1:0] CH_LOW_T  = 16'h0074;
  localparam logic [CHAR_W-1:0] CH_LOW_V  = 16'h0076;
  localparam logic [CHAR_W-1:0] CH_LOW_X  = 16'h0078;
  localparam logic [CHAR_W-1:0] CH_UP_X   = 16'h0058;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 16'h0030;
  localparam logic [CHAR_W-1:0] CH_SEVEN  = 16'h0037;

  // One result candidate inside the decode
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] ch;
    logic              eos;
  } slot_t;

  // One buffered result beat
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              eos;
    logic              last;
  } result_t;

  // Hex digit value: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 16'h0030 && c <= 16'h0039) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 16'h0041 && c <= 16'h0046) || (c >= 16'h0061 && c <= 16'h0066)) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

  // Control letter after \c: {valid, code}
  function automatic logic [7:0] ctrl_code(input logic [CHAR_W-1:0] c);
    logic [7:0] r;
    r = 8'd0;
    if (c >= 16'h0040 && c <= 16'h005F) begin
      r = {1'b1, 2'b00, c[4:0]};
    end else if (c >= 16'h0061 && c <= 16'h007A) begin
      r = {1'b1, 2'b00, c[4:0]};
    end else if (c == 16'h003F) begin
      r = {1'b1, 7'h7F};
    end
    return r;
  endfunction

  // Emitting a number: positive signed value gives its low half
  function automatic logic [CHAR_W:0] accum_emit(input logic [ACCUM_W-1:0] a);
    return {(a != '0) && !a[ACCUM_W-1], a[CHAR_W-1:0]};
  endfunction

endpackage

// ----- hw/rtl/esi_in_if.sv -----
// Interface: source character channel of the escape sequence interpreter.
`timescale 1ns / 1ps

interface esi_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] in_char;
  logic        in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

// ----- hw/rtl/esi_out_if.sv -----
// Interface: decoded character channel of the escape sequence interpreter.
`timescale 1ns / 1ps

interface esi_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_char;
  logic        end_of_string;
  logic        run_last;

  modport source (output valid, output out_char, output end_of_string, output run_last,
                  input ready);
  modport sink   (input valid, input out_char, input end_of_string, input run_last,
                  output ready);
endinterface

// ----- hw/rtl/escape_sequence_interpreter.sv -----
// Top level: streaming backslash escape decoder for 16-bit characters.
`timescale 1ns / 1ps

// Usage:
//   in_stream carries one source character per beat (in_char, in_last); a NUL
//   character or in_last ends the string. out_stream carries decoded characters;
//   end_of_string marks the terminator, run_last the last beat caused by one
//   input beat. An input beat that only advances the parser gives no output.
//   cfg_we/cfg_index/cfg_data write the configuration registers; write them only
//   while the block is idle.
//   An accepted beat is held in the input register, decoded in a single pass once
//   the result buffer has room, and its results are loaded into that buffer.
//   Throughput: one input beat per cycle while each gives at most one result and
//   the receiver is ready; a beat with more results holds the next beat in the
//   input register while the single output port drains the three-entry result buffer.
//   The input register takes a new beat while a result waits downstream, so a
//   stalled receiver costs no input slot until that register is also full.
//   Reset (rst, synchronous) clears the parser to plain text, empties both
//   registers and clears all configuration registers.
module escape_sequence_interpreter
  import esi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  esi_in_if.sink                in_stream,
  esi_out_if.source             out_stream
);

  // Configuration registers
  logic              backref_mode;
  logic [2:0]        quote_count;
  logic [CHAR_W-1:0] quote_char [QUOTE_REGS];

  // Parser state
  parse_mode_t       parse_mode, parse_mode_next;
  logic              brace_open, brace_open_next;
  logic [ACCUM_W-1:0] digit_accum, digit_accum_next;

  // Input register
  logic              ir_valid;
  logic [CHAR_W-1:0] ir_char;
  logic              ir_last;

  // Result buffer
  result_t           res_buf [MAX_RESULTS];
  logic [1:0]        res_cnt;

  // Decode intermediates
  parse_mode_t        step_mode;
  logic               step_brace;
  logic [ACCUM_W-1:0] step_accum;
  slot_t              slot [2];
  slot_t              flush_slot;
  slot_t              term_slot;
  logic               finish;
  result_t            new_res [MAX_RESULTS];
  logic [1:0]         new_cnt;
  logic               quote_hit;
  logic               pop;
  logic               process;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      backref_mode <= 1'b0;
      quote_count  <= 3'd0;
      for (int i = 0; i < QUOTE_REGS; i++) begin
        quote_char[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BACKREF_MODE: backref_mode  <= cfg_data[0];
        CFG_QUOTE_COUNT:  quote_count   <= cfg_data[2:0];
        CFG_QUOTE_CHAR_A: quote_char[0] <= cfg_data;
        CFG_QUOTE_CHAR_B: quote_char[1] <= cfg_data;
        CFG_QUOTE_CHAR_C: quote_char[2] <= cfg_data;
        CFG_QUOTE_CHAR_D: quote_char[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshakes
  assign pop     = out_stream.valid && out_stream.ready;
  assign process = ir_valid && ((res_cnt == 2'd0) || (res_cnt == 2'd1 && out_stream.ready));
  assign in_stream.ready = !ir_valid || process;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_stream.ready) begin
      ir_valid <= in_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_stream.valid && in_stream.ready) begin
      ir_char <= in_stream.in_char;
      ir_last <= in_stream.in_last;
    end
  end

  // Quote set compare
  always_comb begin
    quote_hit = 1'b0;
    for (int i = 0; i < QUOTE_REGS; i++) begin
      if ((3'(i) < quote_count) && (i < QUOTE_LIMIT) && (quote_char[i] == ir_char)) begin
        quote_hit = 1'b1;
      end
    end
  end

  // Step: one character against the current parse mode (slots 0 and 1)
  always_comb begin
    logic [4:0]        hx;
    logic [7:0]        cc;
    logic [CHAR_W:0]   em;
    logic              number_end;
    logic              reparse;

    hx = hex_digit(ir_char);
    cc = ctrl_code(ir_char);
    em = accum_emit(digit_accum);
    number_end = 1'b0;
    reparse    = 1'b0;

    step_mode  = parse_mode;
    step_brace = brace_open;
    step_accum = digit_accum;
    slot[0]    = '0;
    slot[1]    = '0;

    if (ir_char != CH_NUL) begin
      case (parse_mode)
        MODE_ESC: begin
          step_mode = MODE_PLAIN;
          if (quote_hit) begin
            slot[0] = '{1'b1, ir_char, 1'b0};
          end else begin
            case (ir_char)
              CH_LOW_A: slot[0] = '{1'b1, 16'h0007, 1'b0};
              CH_LOW_E: slot[0] = '{1'b1, 16'h001B, 1'b0};
              CH_LOW_F: slot[0] = '{1'b1, 16'h000C, 1'b0};
              CH_LOW_N: slot[0] = '{1'b1, 16'h000A, 1'b0};
              CH_LOW_R: slot[0] = '{1'b1, 16'h000D, 1'b0};
              CH_LOW_T: slot[0] = '{1'b1, 16'h0009, 1'b0};
              CH_LOW_V: slot[0] = '{1'b1, 16'h000B, 1'b0};
              CH_SQUOTE, CH_DQUOTE, CH_BSL: slot[0] = '{1'b1, ir_char, 1'b0};
              CH_LOW_C: step_mode = MODE_CTRL;
              CH_LOW_X, CH_UP_X: begin
                step_mode  = MODE_HEX_START;
                step_accum = '0;
                step_brace = 1'b0;
              end
              default: begin
                if (ir_char >= CH_ZERO && ir_char <= CH_SEVEN &&
                    (ir_char == CH_ZERO || !backref_mode)) begin
                  step_accum = ACCUM_W'(ir_char[2:0]);
                  step_mode  = MODE_OCTAL;
                end else begin
                  slot[0] = '{1'b1, CH_BSL, 1'b0};
                  slot[1] = '{1'b1, ir_char, 1'b0};
                end
              end
            endcase
          end
        end
        MODE_CTRL: begin
          step_mode = MODE_PLAIN;
          if (cc[7]) begin
            slot[0] = '{1'b1, CHAR_W'(cc[6:0]), 1'b0};
          end else begin
            reparse = 1'b1;
          end
        end
        MODE_HEX_START, MODE_HEX_DIGIT: begin
          step_mode = MODE_HEX_DIGIT;
          if (parse_mode == MODE_HEX_START && ir_char == CH_LBRACE) begin
            step_brace = 1'b1;
          end else if (hx[4]) begin
            step_accum = {digit_accum[ACCUM_W-5:0], 4'b0000} + ACCUM_W'(hx[3:0]);
          end else begin
            number_end = 1'b1;
            reparse    = !(ir_char == CH_RBRACE && brace_open);
            step_brace = 1'b0;
          end
        end
        MODE_OCTAL: begin
          if (ir_char >= CH_ZERO && ir_char <= CH_SEVEN) begin
            step_accum = {digit_accum[ACCUM_W-4:0], ir_char[2:0]};
          end else begin
            number_end = 1'b1;
            reparse    = 1'b1;
          end
        end
        default: begin
          reparse = 1'b1;
        end
      endcase

      // Number ended by a non-digit: flush the accumulator
      if (number_end) begin
        slot[0]    = '{em[CHAR_W], em[CHAR_W-1:0], 1'b0};
        step_accum = '0;
        step_mode  = MODE_PLAIN;
      end

      // Character handled as plain text
      if (reparse) begin
        if (ir_char == CH_BSL) begin
          step_mode = MODE_ESC;
        end else begin
          step_mode = MODE_PLAIN;
          slot[1]   = '{1'b1, ir_char, 1'b0};
        end
      end
    end
  end

  // End of string: flush pending form and add the terminator
  always_comb begin
    logic [CHAR_W:0] fem;
    fem    = accum_emit(step_accum);
    finish = (ir_char == CH_NUL) || ir_last;
    flush_slot = '0;
    term_slot  = '0;
    parse_mode_next  = step_mode;
    brace_open_next  = step_brace;
    digit_accum_next = step_accum;
    if (finish) begin
      if (step_mode == MODE_ESC) begin
        flush_slot = '{1'b1, CH_BSL, 1'b0};
      end else if (step_mode == MODE_HEX_DIGIT || step_mode == MODE_OCTAL) begin
        flush_slot = '{fem[CHAR_W], fem[CHAR_W-1:0], 1'b0};
      end
      term_slot = '{1'b1, CH_NUL, 1'b1};
      parse_mode_next  = MODE_PLAIN;
      brace_open_next  = 1'b0;
      digit_accum_next = '0;
    end
  end

  // Pack the first three valid slots, mark the last one
  always_comb begin
    slot_t cand [4];
    cand[0] = slot[0];
    cand[1] = slot[1];
    cand[2] = flush_slot;
    cand[3] = term_slot;
    new_cnt = 2'd0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      new_res[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      if (cand[i].valid && new_cnt != 2'd3) begin
        new_res[new_cnt] = '{cand[i].ch, cand[i].eos, 1'b0};
        new_cnt = new_cnt + 2'd1;
      end
    end
    if (new_cnt != 2'd0) begin
      new_res[new_cnt - 2'd1].last = 1'b1;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode  <= MODE_PLAIN;
      brace_open  <= 1'b0;
      digit_accum <= '0;
    end else if (process) begin
      parse_mode  <= parse_mode_next;
      brace_open  <= brace_open_next;
      digit_accum <= digit_accum_next;
    end
  end

  // Result buffer: load on process, shift down on pop
  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= 2'd0;
    end else if (process) begin
      res_cnt <= new_cnt;
    end else if (pop) begin
      res_cnt <= res_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        res_buf[i] <= new_res[i];
      end
    end else if (pop) begin
      res_buf[0] <= res_buf[1];
      res_buf[1] <= res_buf[2];
    end
  end

  // Output beat
  assign out_stream.valid         = (res_cnt != 2'd0);
  assign out_stream.out_char      = res_buf[0].ch;
  assign out_stream.end_of_string = res_buf[0].eos;
  assign out_stream.run_last      = res_buf[0].last;

endmodule
